@@ sv/ssa_pkg.sv @@
// ssa_pkg: shared types and codes for the sorted set array.
// Operation and status codes, plus the command and flag structs passed
// between the top level and the storage cells. No dependencies.
package ssa_pkg;

	// Operation requested by an item; code 3 is treated as search
	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_SEARCH = 2'd2
	} ssa_mode_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_REMOVED   = 3'd3,
		ST_ABSENT    = 3'd4,
		ST_FOUND     = 3'd5
	} ssa_status_t;

	// Update command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic rem;
	} ssa_cmd_t;

	// Per-cell compare results
	typedef struct packed {
		logic lt;    // valid and key < entry
		logic eq;    // valid and key == entry
		logic mark;  // this cell is the insertion slot
	} ssa_flags_t;

endpackage

@@ sv/ssa_cell.sv @@
// ssa_cell: one slot of the sorted set chain, holding an entry and its valid bit.
// Compares the broadcast key against its entry and shifts with its neighbors.
// Depends on ssa_pkg.
module ssa_cell import ssa_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ssa_cmd_t                      cmd,
	input  logic signed [VALUE_WIDTH-1:0] key,
	input  logic signed [VALUE_WIDTH-1:0] left_entry,
	input  logic                          left_valid,
	input  logic                          left_lt,
	input  logic signed [VALUE_WIDTH-1:0] right_entry,
	input  logic                          right_valid,
	output logic signed [VALUE_WIDTH-1:0] entry,
	output logic                          valid,
	output ssa_flags_t                    flags
);

	logic signed [VALUE_WIDTH-1:0] entry_q;
	logic                          valid_q;
	logic                          take_key;

	assign flags.lt   = valid_q && (key < entry_q);
	assign flags.eq   = valid_q && (key == entry_q);
	// slot for the key: larger than the left entry, and this entry is larger or empty
	assign take_key   = !left_lt && (!valid_q || flags.lt);
	assign flags.mark = take_key && left_valid;

	assign entry = entry_q;
	assign valid = valid_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (left_lt) begin
				entry_q <= left_entry;
			end else if (take_key) begin
				entry_q <= key;
			end
		end else if (cmd.rem) begin
			if (flags.lt || flags.eq) begin
				entry_q <= right_entry;
			end
		end
	end

	// valid bits form a thermometer code that moves with the count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ins) begin
			valid_q <= left_valid;
		end else if (cmd.rem) begin
			valid_q <= right_valid;
		end
	end

endmodule

@@ sv/sorted_set_array.sv @@
// sorted_set_array: top level of the sorted set store.
// Request register, a chain of ssa_cell slots, result register, capacity register.
// Depends on ssa_pkg and ssa_cell.
//
// Usage:
//  - Input channel (in_valid/in_ready, mode, value): one item per operation,
//    insert, remove or search of a signed key. Mode 3 acts as search.
//  - Output channel (out_valid/out_ready): one result item per input item, in
//    order: status, position, count, full_res, empty_res.
//  - Config channel (cfg_valid/cfg_ready, capacity): always ready; write the
//    capacity only while no item is in flight. Values above DEPTH act as DEPTH.
//  - Flow: an accepted item lands in the request register; once the result
//    register is free or being drained, all cells compare it in parallel against
//    their entries, shift with their neighbors, and the result is registered.
//  - Throughput: one item per cycle while the receiver keeps up; the request
//    register is the only stage ahead of the cell chain.
//  - Stall: with the result held, one more item is taken into the request
//    register, then in_ready drops until the result is taken.
//  - Reset: count is zero (all slots empty), capacity is 16, no result pending.
//    Stored entries are not cleared; only slots below the count are ever read.
module sorted_set_array import ssa_pkg::*; #(
	parameter int DEPTH       = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request items
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    mode,
	input  logic signed [VALUE_WIDTH-1:0] value,
	// result items
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    status,
	output logic [3:0]                    position,
	output logic [4:0]                    count,
	output logic                          full_res,
	output logic                          empty_res,
	// capacity register
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [4:0]                    capacity
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > 5) ? CW : 5;

	// request stage
	logic                          req_v_q;
	logic [1:0]                    req_mode_q;
	logic signed [VALUE_WIDTH-1:0] req_key_q;

	// state and result registers
	logic [CW-1:0] count_q;
	logic [4:0]    cap_q;
	logic          out_v_q;
	ssa_status_t   status_q;
	logic [3:0]    position_q;
	logic [4:0]    count_res_q;
	logic          full_q;
	logic          empty_q;

	logic advance;
	logic in_acc;

	// cell chain wiring
	logic signed [VALUE_WIDTH-1:0] cell_entry [DEPTH];
	logic [DEPTH-1:0]              cell_valid;
	ssa_flags_t                    cell_flags [DEPTH];
	logic [DEPTH-1:0]              eq_vec;
	logic [DEPTH-1:0]              mark_vec;
	ssa_cmd_t                      cmd;

	// decode
	logic          hit;
	logic [PW-1:0] hit_pos;
	logic [PW-1:0] ins_pos;
	logic [XW-1:0] eff_cap;
	logic [XW-1:0] cap_x;
	logic [XW-1:0] cnt_x;
	logic [XW-1:0] new_cnt_x;
	logic [CW-1:0] new_count;
	ssa_status_t   res_status;
	logic [PW-1:0] res_pos;
	logic [PW+3:0] pos_ext;
	logic [CW+4:0] cnt_ext;

	// an item moves through when the result register is free or being drained
	assign advance   = req_v_q && (!out_v_q || out_ready);
	assign in_ready  = !req_v_q || advance;
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_v_q <= 1'b0;
		end else if (in_acc) begin
			req_v_q <= 1'b1;
		end else if (advance) begin
			req_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_mode_q <= mode;
			req_key_q  <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 5'd16;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= capacity;
		end
	end

	// the chain: each cell sees its left and right neighbor
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic signed [VALUE_WIDTH-1:0] l_entry;
			logic                          l_valid;
			logic                          l_lt;
			logic signed [VALUE_WIDTH-1:0] r_entry;
			logic                          r_valid;

			if (gi == 0) begin : g_head
				assign l_entry = '0;
				assign l_valid = 1'b1;
				assign l_lt    = 1'b0;
			end else begin : g_mid_l
				assign l_entry = cell_entry[gi-1];
				assign l_valid = cell_valid[gi-1];
				assign l_lt    = cell_flags[gi-1].lt;
			end

			if (gi == DEPTH - 1) begin : g_tail
				assign r_entry = '0;
				assign r_valid = 1'b0;
			end else begin : g_mid_r
				assign r_entry = cell_entry[gi+1];
				assign r_valid = cell_valid[gi+1];
			end

			ssa_cell #(
				.VALUE_WIDTH(VALUE_WIDTH)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.cmd        (cmd),
				.key        (req_key_q),
				.left_entry (l_entry),
				.left_valid (l_valid),
				.left_lt    (l_lt),
				.right_entry(r_entry),
				.right_valid(r_valid),
				.entry      (cell_entry[gi]),
				.valid      (cell_valid[gi]),
				.flags      (cell_flags[gi])
			);

			assign eq_vec[gi]   = cell_flags[gi].eq;
			assign mark_vec[gi] = cell_flags[gi].mark;
		end
	endgenerate

	// one-hot to index for the match slot and the insertion slot
	always_comb begin
		hit_pos = '0;
		ins_pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (eq_vec[i]) begin
				hit_pos = hit_pos | PW'(i);
			end
			if (mark_vec[i]) begin
				ins_pos = ins_pos | PW'(i);
			end
		end
	end

	assign hit     = |eq_vec;
	assign cap_x   = XW'(cap_q);
	assign eff_cap = (cap_x > XW'(DEPTH)) ? XW'(DEPTH) : cap_x;
	assign cnt_x   = XW'(count_q);

	// operation decode; full check wins over duplicate on insert
	always_comb begin
		cmd        = '0;
		res_status = ST_ABSENT;
		res_pos    = '0;
		new_count  = count_q;
		case (req_mode_q)
			MODE_INSERT: begin
				if (cnt_x >= eff_cap) begin
					res_status = ST_FULL;
				end else if (hit) begin
					res_status = ST_DUPLICATE;
				end else begin
					res_status = ST_INSERTED;
					res_pos    = ins_pos;
					cmd.ins    = advance;
					new_count  = count_q + 1'b1;
				end
			end
			MODE_REMOVE: begin
				if (hit) begin
					res_status = ST_REMOVED;
					res_pos    = hit_pos;
					cmd.rem    = advance;
					new_count  = count_q - 1'b1;
				end
			end
			default: begin
				if (hit) begin
					res_status = ST_FOUND;
					res_pos    = hit_pos;
				end
			end
		endcase
	end

	assign new_cnt_x = XW'(new_count);
	assign pos_ext   = {4'b0, res_pos};
	assign cnt_ext   = {5'b0, new_count};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (advance) begin
				count_q <= new_count;
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q    <= res_status;
			position_q  <= pos_ext[3:0];
			count_res_q <= cnt_ext[4:0];
			full_q      <= (new_cnt_x >= eff_cap);
			empty_q     <= (new_count == '0);
		end
	end

	assign out_valid = out_v_q;
	assign status    = status_q;
	assign position  = position_q;
	assign count     = count_res_q;
	assign full_res  = full_q;
	assign empty_res = empty_q;

	// valid bits of the chain track the count exactly
	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == int'(count_q))
		else $error("cell valid bits disagree with count");

	// keys are distinct, so at most one slot can match
	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(eq_vec))
		else $error("more than one slot matches the key");

	// an insert that goes through lands in exactly one slot
	a_one_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |-> $onehot(mark_vec))
		else $error("insert without a unique slot");

	// a moved item always leaves a result behind
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_v_q)
		else $error("result lost after advance");

endmodule

@@ bench/sorted_set_array_tb.sv @@
// sorted_set_array_tb: self-checking bench for the sorted set store.
// Drives insert/remove/search items across many capacity settings and checks every result item
// against an in-bench copy of the set. Depends on ssa_pkg and sorted_set_array.
module sorted_set_array_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ssa_pkg::*;

	localparam int DEPTH        = 16;
	localparam int IDLE_PCT     = 6;   // chance per cycle that a side idles
	localparam int HOLD_CYCLES  = 80;  // long output stall in the pressure phase
	localparam int DRAIN_CYCLES = 6;   // margin after every result is back
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 115;
	localparam int POOL_SIZE    = 20;

	// mode 3 has no enum member; the block treats it as a search
	localparam logic [1:0] MODE_SEARCH_ALIAS = 2'd3;
	localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

	typedef struct {
		logic [1:0]         op;
		logic signed [31:0] key;
	} set_request_t;

	typedef struct {
		logic [2:0] status;
		logic [3:0] pos;
		logic [4:0] cnt;
		logic       full;
		logic       empty;
	} set_result_t;

	// DUT-facing signals; the ones the bench drives are known from time zero
	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              in_valid   = 1'b0;
	logic              in_ready;
	logic [1:0]        req_mode   = MODE_INSERT;
	logic signed [31:0] req_value = '0;
	logic              out_valid;
	logic              out_ready  = 1'b0;
	logic [2:0]        res_status;
	logic [3:0]        res_position;
	logic [4:0]        res_count;
	logic              res_full;
	logic              res_empty;
	logic              cfg_valid  = 1'b0;
	logic              cfg_ready;
	logic [4:0]        cap_wdata  = 5'd16;

	// Bench state
	set_request_t pending_requests[$];   // items not yet offered to the block
	set_result_t  awaited_results[$];    // predicted results, oldest first
	set_request_t next_req;
	set_result_t  got_want;
	logic         req_taken = 1'b0;      // input item accepted at the last rising edge
	bit           calm = 1'b0;           // no idling on either side
	bit           hold_phase = 1'b0;     // receiver does one long stall
	bit           hold_done = 1'b0;
	int           hold_cnt = 0;
	int           fail_count = 0;
	int           results_checked = 0;
	int           cap_writes = 0;
	int           status_tally[8];
	logic [4:0]   phase_caps[PHASES];

	// Shadow copy of the set: entries in ascending order, count and capacity register
	logic signed [31:0] set_keys[DEPTH];
	int                 set_count = 0;
	logic [4:0]         cap_model = 5'd16;

	sorted_set_array #(
		.DEPTH(DEPTH),
		.VALUE_WIDTH(32)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (req_mode),
		.value    (req_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (res_status),
		.position (res_position),
		.count    (res_count),
		.full_res (res_full),
		.empty_res(res_empty),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.capacity (cap_wdata)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Apply one operation to the shadow set and return the result item it must produce.
	// Full is checked before duplicate; capacity above DEPTH saturates; capacity zero
	// rejects every insert.
	function automatic set_result_t sorted_set_apply(input logic [1:0] op,
			input logic signed [31:0] key);
		set_result_t r;
		int limit;
		int hit;
		int slot;
		limit = (cap_model > DEPTH) ? DEPTH : int'(cap_model);
		hit = -1;
		for (int i = set_count - 1; i >= 0; i--)
			if (set_keys[i] == key)
				hit = i;
		r.pos = '0;
		case (op)
			MODE_INSERT: begin
				if (set_count >= limit) begin
					r.status = ST_FULL;
				end else if (hit >= 0) begin
					r.status = ST_DUPLICATE;
				end else begin
					// first entry above the key takes its place, the rest move up
					slot = set_count;
					for (int i = set_count - 1; i >= 0; i--)
						if (key < set_keys[i])
							slot = i;
					for (int i = set_count; i > slot; i--)
						set_keys[i] = set_keys[i - 1];
					set_keys[slot] = key;
					set_count++;
					r.status = ST_INSERTED;
					r.pos = slot[3:0];
				end
			end
			MODE_REMOVE: begin
				if (hit >= 0) begin
					for (int i = hit; i < set_count - 1; i++)
						set_keys[i] = set_keys[i + 1];
					set_count--;
					r.status = ST_REMOVED;
					r.pos = hit[3:0];
				end else begin
					r.status = ST_ABSENT;
				end
			end
			default: begin
				// search and its alias
				if (hit >= 0) begin
					r.status = ST_FOUND;
					r.pos = hit[3:0];
				end else begin
					r.status = ST_ABSENT;
				end
			end
		endcase
		r.cnt   = set_count[4:0];
		r.full  = (set_count >= limit);
		r.empty = (set_count == 0);
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= 40)
				$display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		end
	endfunction

	// Sender: a new item goes out at the falling edge once the previous one was taken.
	always @(negedge clk) begin
		if (!in_valid || req_taken) begin
			if (pending_requests.size() != 0 &&
					(calm || $urandom_range(99) >= IDLE_PCT)) begin
				next_req = pending_requests.pop_front();
				in_valid  <= 1'b1;
				req_mode  <= next_req.op;
				req_value <= next_req.key;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random short stalls, plus one long stall in the pressure phase so
	// the request register and result register both fill and in_ready drops.
	always @(negedge clk) begin
		if (hold_phase && !hold_done) begin
			out_ready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
			if (hold_cnt == HOLD_CYCLES - 1)
				hold_done <= 1'b1;
		end else begin
			if (!hold_phase) begin
				hold_done <= 1'b0;
				hold_cnt <= 0;
			end
			out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Monitor: all handshakes are sampled at the rising edge. Results are checked
	// before new items are predicted, though a result never belongs to the item
	// taken at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				cap_model = cap_wdata;
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					fail_count++;
					$display("%0t ns: result item with nothing outstanding, status %0d",
						$time, res_status);
				end else begin
					got_want = awaited_results.pop_front();
					check_field("status", got_want.status, res_status);
					check_field("position", got_want.pos, res_position);
					check_field("count", got_want.cnt, res_count);
					check_field("full_res", got_want.full, res_full);
					check_field("empty_res", got_want.empty, res_empty);
					status_tally[got_want.status]++;
					results_checked++;
				end
			end
			if (in_valid && in_ready)
				awaited_results.push_back(sorted_set_apply(req_mode, req_value));
		end
		req_taken <= arst_n && in_valid && in_ready;
	end

	task automatic queue_req(input logic [1:0] op, input logic signed [31:0] key);
		set_request_t req;
		req.op = op;
		req.key = key;
		pending_requests.push_back(req);
	endtask

	// Idle means: nothing left to offer, nothing on the input, every result back.
	task automatic wait_idle();
		while (pending_requests.size() != 0 || in_valid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [4:0] cap);
		wait_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cap_wdata <= cap;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
		cap_writes++;
	endtask

	// Random phase: keys drawn mostly from a small pool so that duplicates, hits on
	// remove and full stores are common; the pool mixes random words, small values and
	// values near both extremes. A tenth of the keys are fully random.
	task automatic queue_random_phase(input int n, input int ins_pct);
		logic signed [31:0] keypool[POOL_SIZE];
		logic [1:0] op;
		logic signed [31:0] key;
		int r;
		for (int i = 0; i < POOL_SIZE; i++) begin
			case (i % 5)
				1: keypool[i] = 32'($urandom_range(40)) - 32'd20;
				2: keypool[i] = KEY_MIN + 32'($urandom_range(3));
				3: keypool[i] = KEY_MAX - 32'($urandom_range(3));
				default: keypool[i] = $urandom;
			endcase
		end
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < ins_pct) begin
				op = MODE_INSERT;
			end else begin
				r = $urandom_range(99);
				op = (r < 55) ? MODE_REMOVE : (r < 93) ? MODE_SEARCH : MODE_SEARCH_ALIAS;
			end
			key = ($urandom_range(9) == 0) ? $urandom : keypool[$urandom_range(POOL_SIZE - 1)];
			queue_req(op, key);
		end
	endtask

	initial begin
		foreach (set_keys[i])
			set_keys[i] = '0;
		foreach (status_tally[i])
			status_tally[i] = 0;
		// extremes 0, 1, 16 and 31 (saturates), plus values in between
		phase_caps = '{5'd31, 5'd16, 5'd1, 5'd5, 5'd0, 5'd16, 5'd17, 5'd8, 5'd3, 5'd16};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset capacity of 16.
		// Empty store: search and remove both report absent.
		queue_req(MODE_SEARCH, 32'sd0);
		queue_req(MODE_REMOVE, 32'sd5);
		// Build 0, MIN, MAX, -1, 1 so inserts land at front, back and middle
		queue_req(MODE_INSERT, 32'sd0);
		queue_req(MODE_INSERT, KEY_MIN);
		queue_req(MODE_INSERT, KEY_MAX);
		queue_req(MODE_INSERT, -32'sd1);
		queue_req(MODE_INSERT, 32'sd1);
		queue_req(MODE_INSERT, 32'sd0);          // duplicate
		queue_req(MODE_SEARCH, KEY_MAX);
		queue_req(MODE_SEARCH_ALIAS, KEY_MIN);   // mode 3 acts as search
		queue_req(MODE_SEARCH, 32'sd7);          // absent
		queue_req(MODE_REMOVE, -32'sd1);
		queue_req(MODE_REMOVE, KEY_MIN);
		queue_req(MODE_REMOVE, KEY_MAX);
		queue_req(MODE_REMOVE, 32'sd42);         // absent
		queue_req(MODE_SEARCH, 32'sd1);

		// Capacity 2 with two entries held: full is reported ahead of duplicate.
		write_capacity(5'd2);
		queue_req(MODE_INSERT, 32'sd3);
		queue_req(MODE_INSERT, 32'sd0);
		queue_req(MODE_REMOVE, 32'sd0);
		queue_req(MODE_INSERT, 32'sd3);

		// Capacity dropped to zero below the count: entries kept, inserts rejected,
		// full stays set even after a remove.
		write_capacity(5'd0);
		queue_req(MODE_INSERT, 32'sd7);
		queue_req(MODE_REMOVE, 32'sd1);
		queue_req(MODE_SEARCH, 32'sd3);

		// Random phases, one per capacity setting. Phase 1 has the long output stall,
		// phase 5 runs with no idling at all.
		for (int p = 0; p < PHASES; p++) begin
			write_capacity(phase_caps[p]);
			calm = (p == 5);
			hold_phase = (p == 1);
			queue_random_phase(PHASE_ITEMS, (phase_caps[p] >= 8) ? 65 : 50);
		end

		wait_idle();
		if (awaited_results.size() != 0) begin
			fail_count++;
			$display("%0t ns: %0d results never arrived", $time, awaited_results.size());
		end

		$display("Run: %0d result items checked over %0d capacity writes, one %0d-cycle stall.",
			results_checked, cap_writes, HOLD_CYCLES);
		$display("Outcomes: inserted %0d, duplicate %0d, full %0d, removed %0d, absent %0d, found %0d",
			status_tally[ST_INSERTED], status_tally[ST_DUPLICATE], status_tally[ST_FULL],
			status_tally[ST_REMOVED], status_tally[ST_ABSENT], status_tally[ST_FOUND]);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog: ends a run that hangs.
	initial begin
		#200us;
		$display("%0t ns: timeout, %0d results outstanding", $time, awaited_results.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
